// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker module of the project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define CHK_ASSERT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define CHK_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/cpt_pkg.sv -----
// types and constants of the cpu tick percentage core
package cpt_pkg;

  // number of tick counters in one word
  localparam int NUM_CTR = 5;
  // bits of a counter position index
  localparam int CTR_IDX_W = 3;
  // bits of one percentage
  localparam int PCT_W = 7;

  // action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [3:0]  machine;
    logic [31:0] ticks_slot0;
    logic [31:0] ticks_slot1;
    logic [31:0] ticks_slot2;
    logic [31:0] ticks_slot3;
    logic [31:0] ticks_slot4;
  } item_t;

  typedef struct packed {
    logic [3:0]       machine_out;
    logic [PCT_W-1:0] pct0;
    logic [PCT_W-1:0] pct1;
    logic [PCT_W-1:0] pct2;
    logic [PCT_W-1:0] pct3;
    logic [PCT_W-1:0] pct4;
  } result_t;

  // raw counter position reported at output position j (3 and 4 swapped)
  function automatic logic [CTR_IDX_W-1:0] raw_of_out(input logic [CTR_IDX_W-1:0] j);
    logic [CTR_IDX_W-1:0] r;
    case (j)
      3'd3:    r = 3'd4;
      3'd4:    r = 3'd3;
      default: r = j;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/cpu_tick_percentages_core.sv -----
// top level of the cpu tick percentage core
// Each sample word names a machine slot and carries five cumulative tick
// counters. The core keeps the previous counters per slot in a small memory
// and reports each wrapping delta as a truncated percentage of the delta sum,
// with raw counters 3 and 4 swapped in the result. A sample word with a result
// keeps busy high while the core reads and rewrites the five stored counters
// through the single memory port, checks the slot flag and runs the shared
// divider once for each of the five counters. The first sample after reset or
// after a clear of the slot keeps busy high through the reads, the rewrites
// and the flag check and gives no result. A clear word and a word for a slot at
// or beyond MACHINES give no result and leave busy low. The result word is on result
// for exactly one cycle with done high and must be taken then.
module cpu_tick_percentages_core import cpt_pkg::*; #(
  parameter int MACHINES     = 16,
  parameter int COUNTER_BITS = 32
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  localparam int SLOT_W = (MACHINES > 1) ? $clog2(MACHINES) : 1;
  localparam int DEPTH  = MACHINES * NUM_CTR;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = COUNTER_BITS + 3;
  localparam int DIV_W  = COUNTER_BITS + 10;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DELTA,
    S_CHECK,
    S_DIV_START,
    S_DIV_WAIT
  } state_t;

  state_t state;

  logic [COUNTER_BITS-1:0] now   [NUM_CTR];
  logic [COUNTER_BITS-1:0] delta [NUM_CTR];
  logic [PCT_W-1:0]        pct   [NUM_CTR];
  logic [MACHINES-1:0]     first_pending;
  logic [SUM_W-1:0]        sum;
  logic [ADDR_W-1:0]       addr;
  logic [SLOT_W-1:0]       slot;
  logic [3:0]              machine;
  logic [CTR_IDX_W-1:0]    idx;

  logic [COUNTER_BITS-1:0] mem [DEPTH];
  logic [COUNTER_BITS-1:0] rdata;

  logic                    accept;
  logic                    slot_ok;
  logic [COUNTER_BITS-1:0] diff;
  logic [COUNTER_BITS-1:0] div_d;
  logic [DIV_W-1:0]        div_num;
  logic                    div_start;
  logic                    div_done;
  logic [PCT_W-1:0]        div_quot;

  assign accept  = start && !busy;
  assign slot_ok = 32'(item.machine) < MACHINES;
  assign busy    = (state != S_IDLE);

  // wrapping delta of the counter under work
  assign diff = now[idx] - rdata;

  // dividend is delta times 100, built as 64 + 32 + 4
  assign div_d     = delta[raw_of_out(idx)];
  assign div_num   = (DIV_W'(div_d) << 6) + (DIV_W'(div_d) << 5) + (DIV_W'(div_d) << 2);
  assign div_start = (state == S_DIV_START);

  // previous counters, read old data while the new counter is written
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (state == S_READ) begin
      mem[addr] <= now[idx];
    end
  end

  cpt_pct_div #(
    .W(DIV_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (DIV_W'(sum)),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      first_pending <= '1;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && slot_ok) begin
            slot    <= SLOT_W'(item.machine);
            machine <= item.machine;
            if (item.action == ACT_CLEAR) begin
              first_pending[SLOT_W'(item.machine)] <= 1'b1;
            end else begin
              now[0] <= COUNTER_BITS'(item.ticks_slot0);
              now[1] <= COUNTER_BITS'(item.ticks_slot1);
              now[2] <= COUNTER_BITS'(item.ticks_slot2);
              now[3] <= COUNTER_BITS'(item.ticks_slot3);
              now[4] <= COUNTER_BITS'(item.ticks_slot4);
              addr   <= ADDR_W'(32'(item.machine) * NUM_CTR);
              idx    <= '0;
              sum    <= '0;
              state  <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_DELTA;
        end
        S_DELTA: begin
          delta[idx] <= diff;
          sum        <= sum + SUM_W'(diff);
          addr       <= addr + 1'b1;
          if (idx == CTR_IDX_W'(NUM_CTR - 1)) begin
            state <= S_CHECK;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_READ;
          end
        end
        S_CHECK: begin
          idx <= '0;
          if (first_pending[slot]) begin
            first_pending[slot] <= 1'b0;
            state               <= S_IDLE;
          end else begin
            if (sum == '0) begin
              sum <= SUM_W'(1);
            end
            state <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            pct[idx] <= div_quot;
            if (idx == CTR_IDX_W'(NUM_CTR - 1)) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DIV_START;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result word, already in output order
  assign result.machine_out = machine;
  assign result.pct0        = pct[0];
  assign result.pct1        = pct[1];
  assign result.pct2        = pct[2];
  assign result.pct3        = pct[3];
  assign result.pct4        = pct[4];

endmodule

// ----- rtl/core/cpt_pct_div.sv -----
// iterative restoring divider giving a 7-bit quotient, one bit a cycle
module cpt_pct_div import cpt_pkg::*; #(
  parameter int W = 42
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [W-1:0]     num,
  input  logic [W-1:0]     den,
  output logic             done,
  output logic [PCT_W-1:0] quot
);

  logic [W-1:0]         rem;
  logic [W-1:0]         dsh;
  logic [CTR_IDX_W-1:0] bitpos;
  logic                 run;

  // one compare and subtract per cycle, divisor shifted down each step
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem    <= num;
        dsh    <= den << (PCT_W - 1);
        bitpos <= CTR_IDX_W'(PCT_W - 1);
        quot   <= '0;
        run    <= 1'b1;
      end else if (run) begin
        if (rem >= dsh) begin
          rem          <= rem - dsh;
          quot[bitpos] <= 1'b1;
        end
        dsh <= dsh >> 1;
        if (bitpos == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          bitpos <= bitpos - 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/cpt_core_chk.sv -----
// port-level checker of the cpu tick percentage core, with its bind
`include "assert_macros.svh"

module cpt_core_chk import cpt_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input logic    done,
  input result_t result
);

  logic [PCT_W+2:0] pct_total;

  assign pct_total = (PCT_W+3)'(result.pct0) + (PCT_W+3)'(result.pct1)
                   + (PCT_W+3)'(result.pct2) + (PCT_W+3)'(result.pct3)
                   + (PCT_W+3)'(result.pct4);

  // a result comes out only once the core is free again
  `CHK_ASSERT(a_done_idle, clk, rst, done, !busy, "result shown while busy")
  // a result is a single-cycle strobe
  `CHK_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result held two cycles")
  // no result can follow an accepted word in the very next cycle
  `CHK_ASSERT_NEXT(a_no_fast_result, clk, rst, start && !busy, !done,
    "result right after accept")
  // truncated shares never add up past one hundred
  `CHK_ASSERT(a_pct_total, clk, rst, done, pct_total <= (PCT_W+3)'(100),
    "percentages exceed one hundred")

endmodule

bind cpu_tick_percentages_core cpt_core_chk u_cpt_core_chk (.*);
